>>> hdl/qtl_pkg.sv
package qtl_pkg;

   // default width of the internal position counters
   localparam int POSITION_WIDTH_DEF = 16;

   // most results one source byte can cause
   localparam int MAX_RESULTS = 4;

   // depth of the queue between the lexer and the result serializer
   localparam int QUEUE_DEPTH = 2;

   // result types
   localparam logic [1:0] RES_CONTENT = 2'd0;
   localparam logic [1:0] RES_TOKEN   = 2'd1;
   localparam logic [1:0] RES_ERROR   = 2'd2;

   // token kinds
   localparam logic [3:0] KIND_STRING = 4'd0;
   localparam logic [3:0] KIND_REGEX  = 4'd1;
   localparam logic [3:0] KIND_NUMBER = 4'd2;
   localparam logic [3:0] KIND_OP     = 4'd3;
   localparam logic [3:0] KIND_LPAREN = 4'd4;
   localparam logic [3:0] KIND_RPAREN = 4'd5;
   localparam logic [3:0] KIND_COMMA  = 4'd6;
   localparam logic [3:0] KIND_WORD   = 4'd7;
   localparam logic [3:0] KIND_END    = 4'd8;

   // operator codes
   localparam logic [2:0] OP_EQ   = 3'd0;
   localparam logic [2:0] OP_NE   = 3'd1;
   localparam logic [2:0] OP_LT   = 3'd2;
   localparam logic [2:0] OP_LE   = 3'd3;
   localparam logic [2:0] OP_GT   = 3'd4;
   localparam logic [2:0] OP_GE   = 3'd5;
   localparam logic [2:0] OP_STAR = 3'd6;

   // error codes
   localparam logic [1:0] ERR_OPEN_STRING = 2'd0;
   localparam logic [1:0] ERR_OPEN_REGEX  = 2'd1;
   localparam logic [1:0] ERR_BANG        = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED  = 2'd3;

   // source characters with a meaning of their own
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_MORE   = 8'h3E;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   // one result as it leaves the block
   typedef struct packed {
      logic [1:0]  res_type;
      logic [3:0]  token_kind;
      logic [2:0]  op_code;
      logic [7:0]  content_byte;
      logic [15:0] position;
      logic [15:0] span_length;
      logic [1:0]  error_code;
   } qtl_result_type;

   // all results of one request, oldest in slot 0
   typedef struct packed {
      logic [2:0]                       count;
      qtl_result_type [MAX_RESULTS-1:0] slot;
   } qtl_bundle_type;

   // character classes, ASCII only
   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic word_first(input logic [7:0] c);
      return is_alpha(c) || (c == CH_UNDER);
   endfunction

   function automatic logic word_next(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c inside {CH_UNDER, CH_DOT, CH_COLON});
   endfunction

   // result builders
   function automatic qtl_result_type mk_content(input logic [7:0] c);
      qtl_result_type r;
      r = '0;
      r.res_type = RES_CONTENT;
      r.content_byte = c;
      return r;
   endfunction

   function automatic qtl_result_type mk_token(input logic [3:0] kind, input logic [2:0] op,
                                               input logic [15:0] pos, input logic [15:0] span);
      qtl_result_type r;
      r = '0;
      r.res_type = RES_TOKEN;
      r.token_kind = kind;
      r.op_code = op;
      r.position = pos;
      r.span_length = span;
      return r;
   endfunction

   function automatic qtl_result_type mk_error(input logic [1:0] code, input logic [15:0] pos);
      qtl_result_type r;
      r = '0;
      r.res_type = RES_ERROR;
      r.error_code = code;
      r.position = pos;
      return r;
   endfunction

endpackage

>>> hdl/qtl_front.sv
module qtl_front #(
   parameter int POSITION_WIDTH = qtl_pkg::POSITION_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [7:0]              req_char_in,
   input  logic                    req_end_of_input,
   input  logic                    q_full,
   output logic                    q_push,
   output qtl_pkg::qtl_bundle_type q_data
);
   import qtl_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam int NCAND = 5;

   typedef enum logic [11:0] {
      MODE_IDLE    = 12'b0000_0000_0001,
      MODE_STR     = 12'b0000_0000_0010,
      MODE_STR_ESC = 12'b0000_0000_0100,
      MODE_RGX     = 12'b0000_0000_1000,
      MODE_RGX_ESC = 12'b0000_0001_0000,
      MODE_INT     = 12'b0000_0010_0000,
      MODE_FRAC    = 12'b0000_0100_0000,
      MODE_WORD    = 12'b0000_1000_0000,
      MODE_LT      = 12'b0001_0000_0000,
      MODE_GT      = 12'b0010_0000_0000,
      MODE_BANG    = 12'b0100_0000_0000,
      MODE_SIGN    = 12'b1000_0000_0000
   } lexer_mode_type;

   lexer_mode_type mode_ff, mode_in, mode_nx;
   logic [PW-1:0]  start_ff, start_in, start_nx;
   logic [PW-1:0]  pos_ff, pos_in, pos_inc, fin_span;
   logic           minus_ff, minus_in, minus_nx;
   logic           halt_ff, halt_in, halt_nx;
   logic           accept, do_fresh;
   logic [7:0]     c;

   qtl_result_type [NCAND-1:0] cand;
   logic [NCAND-1:0]           cval;
   qtl_bundle_type             bundle;
   logic [2:0]                 fill;

   // low 16 bits of a position, zero extended when positions are narrower
   function automatic logic [15:0] out16(input logic [PW-1:0] v);
      logic [PW+15:0] ext;
      ext = {16'b0, v};
      return ext[15:0];
   endfunction

   assign c      = req_char_in;
   assign accept = push && !q_full;

   // saturating increment of the byte position
   assign pos_inc = (pos_ff == {PW{1'b1}}) ? pos_ff : pos_ff + 1'b1;

   // classify the byte: candidates from the open token, the fresh byte and end of text
   always_comb begin
      mode_nx  = mode_ff;
      start_nx = start_ff;
      minus_nx = minus_ff;
      halt_nx  = halt_ff;
      do_fresh = 1'b0;
      cand     = '0;
      cval     = '0;
      fin_span = '0;
      if (!halt_ff) begin
         // continue or close the open token
         case (mode_ff)
            MODE_STR: begin
               if (c == CH_BSLASH) begin
                  mode_nx = MODE_STR_ESC;
               end else if (c == CH_QUOTE) begin
                  cand[0] = mk_token(KIND_STRING, OP_EQ, out16(start_ff),
                                     out16(pos_inc - start_ff));
                  cval[0] = 1'b1;
                  mode_nx = MODE_IDLE;
               end else begin
                  cand[0] = mk_content(c);
                  cval[0] = 1'b1;
               end
            end
            MODE_STR_ESC: begin
               cand[0] = mk_content(c);
               cval[0] = 1'b1;
               mode_nx = MODE_STR;
            end
            MODE_RGX: begin
               if (c == CH_SLASH) begin
                  cand[0] = mk_token(KIND_REGEX, OP_EQ, out16(start_ff),
                                     out16(pos_inc - start_ff));
                  mode_nx = MODE_IDLE;
               end else begin
                  cand[0] = mk_content(c);
                  if (c == CH_BSLASH) begin
                     mode_nx = MODE_RGX_ESC;
                  end
               end
               cval[0] = 1'b1;
            end
            MODE_RGX_ESC: begin
               cand[0] = mk_content(c);
               cval[0] = 1'b1;
               mode_nx = MODE_RGX;
            end
            MODE_SIGN: begin
               if (is_digit(c)) begin
                  cand[0] = mk_content(minus_ff ? CH_MINUS : CH_PLUS);
                  cand[1] = mk_content(c);
                  cval[1:0] = 2'b11;
                  mode_nx = MODE_INT;
               end else begin
                  cand[0] = mk_error(ERR_UNEXPECTED, out16(start_ff));
                  cval[0] = 1'b1;
                  halt_nx = 1'b1;
                  mode_nx = MODE_IDLE;
               end
               minus_nx = 1'b0;
            end
            MODE_BANG: begin
               if (c == CH_EQUAL) begin
                  cand[0] = mk_token(KIND_OP, OP_NE, out16(start_ff),
                                     out16(pos_inc - start_ff));
               end else begin
                  cand[0] = mk_error(ERR_BANG, out16(start_ff));
                  halt_nx = 1'b1;
               end
               cval[0] = 1'b1;
               mode_nx = MODE_IDLE;
            end
            MODE_LT, MODE_GT: begin
               mode_nx = MODE_IDLE;
               cval[0] = 1'b1;
               if (c == CH_EQUAL) begin
                  cand[0] = mk_token(KIND_OP, (mode_ff == MODE_LT) ? OP_LE : OP_GE,
                                     out16(start_ff), out16(pos_inc - start_ff));
               end else begin
                  cand[0] = mk_token(KIND_OP, (mode_ff == MODE_LT) ? OP_LT : OP_GT,
                                     out16(start_ff), 16'd1);
                  do_fresh = 1'b1;
               end
            end
            MODE_INT, MODE_FRAC, MODE_WORD: begin
               cval[0] = 1'b1;
               if ((mode_ff == MODE_WORD) ? word_next(c) : is_digit(c)) begin
                  cand[0] = mk_content(c);
               end else if ((mode_ff == MODE_INT) && (c == CH_DOT)) begin
                  cand[0] = mk_content(c);
                  mode_nx = MODE_FRAC;
               end else begin
                  cand[0] = mk_token((mode_ff == MODE_WORD) ? KIND_WORD : KIND_NUMBER,
                                     OP_EQ, out16(start_ff), out16(pos_ff - start_ff));
                  do_fresh = 1'b1;
               end
            end
            default: begin
               do_fresh = 1'b1;
            end
         endcase

         // a byte outside any token starts one
         if (do_fresh) begin
            mode_nx  = MODE_IDLE;
            start_nx = pos_ff;
            cval[2]  = 1'b1;
            if (is_space(c)) begin
               cval[2] = 1'b0;
            end else if (c == CH_QUOTE) begin
               cval[2] = 1'b0;
               mode_nx = MODE_STR;
            end else if (c == CH_SLASH) begin
               cval[2] = 1'b0;
               mode_nx = MODE_RGX;
            end else if (is_digit(c)) begin
               cand[2] = mk_content(c);
               mode_nx = MODE_INT;
            end else if ((c == CH_MINUS) || (c == CH_PLUS)) begin
               cval[2]  = 1'b0;
               minus_nx = (c == CH_MINUS);
               mode_nx  = MODE_SIGN;
            end else if (c == CH_EQUAL) begin
               cand[2] = mk_token(KIND_OP, OP_EQ, out16(pos_ff), 16'd1);
            end else if (c == CH_BANG) begin
               cval[2] = 1'b0;
               mode_nx = MODE_BANG;
            end else if (c == CH_LESS) begin
               cval[2] = 1'b0;
               mode_nx = MODE_LT;
            end else if (c == CH_MORE) begin
               cval[2] = 1'b0;
               mode_nx = MODE_GT;
            end else if (c == CH_STAR) begin
               cand[2] = mk_token(KIND_OP, OP_STAR, out16(pos_ff), 16'd1);
            end else if (c == CH_LPAREN) begin
               cand[2] = mk_token(KIND_LPAREN, OP_EQ, out16(pos_ff), 16'd1);
            end else if (c == CH_RPAREN) begin
               cand[2] = mk_token(KIND_RPAREN, OP_EQ, out16(pos_ff), 16'd1);
            end else if (c == CH_COMMA) begin
               cand[2] = mk_token(KIND_COMMA, OP_EQ, out16(pos_ff), 16'd1);
            end else if (word_first(c)) begin
               cand[2] = mk_content(c);
               mode_nx = MODE_WORD;
            end else begin
               cand[2] = mk_error(ERR_UNEXPECTED, out16(pos_ff));
               halt_nx = 1'b1;
            end
         end

         // final byte: close the open token; end marker unless that is an error
         if (req_end_of_input && !halt_nx) begin
            fin_span = pos_inc - start_nx;
            cval[4]  = 1'b1;
            cand[4]  = mk_token(KIND_END, OP_EQ, out16(pos_inc), 16'd0);
            cval[3]  = 1'b1;
            case (mode_nx)
               MODE_STR, MODE_STR_ESC: begin
                  cand[3] = mk_error(ERR_OPEN_STRING, out16(start_nx));
                  cval[4] = 1'b0;
               end
               MODE_RGX, MODE_RGX_ESC: begin
                  cand[3] = mk_error(ERR_OPEN_REGEX, out16(start_nx));
                  cval[4] = 1'b0;
               end
               MODE_BANG: begin
                  cand[3] = mk_error(ERR_BANG, out16(start_nx));
                  cval[4] = 1'b0;
               end
               MODE_SIGN: begin
                  cand[3] = mk_error(ERR_UNEXPECTED, out16(start_nx));
                  cval[4] = 1'b0;
               end
               MODE_INT, MODE_FRAC: begin
                  cand[3] = mk_token(KIND_NUMBER, OP_EQ, out16(start_nx), out16(fin_span));
               end
               MODE_WORD: begin
                  cand[3] = mk_token(KIND_WORD, OP_EQ, out16(start_nx), out16(fin_span));
               end
               MODE_LT: begin
                  cand[3] = mk_token(KIND_OP, OP_LT, out16(start_nx), 16'd1);
               end
               MODE_GT: begin
                  cand[3] = mk_token(KIND_OP, OP_GT, out16(start_nx), 16'd1);
               end
               default: begin
                  cval[3] = 1'b0;
               end
            endcase
         end
      end
   end

   // pack the valid candidates into consecutive slots
   always_comb begin
      bundle = '0;
      fill   = '0;
      for (int i = 0; i < NCAND; i++) begin
         if (cval[i] && (fill < 3'(MAX_RESULTS))) begin
            bundle.slot[fill[1:0]] = cand[i];
            fill = fill + 3'd1;
         end
      end
      bundle.count = fill;
   end

   assign q_push = accept && (fill != 3'd0);
   assign q_data = bundle;

   // lexer state update, the final byte returns everything to reset values
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      minus_in = minus_ff;
      halt_in  = halt_ff;
      if (accept) begin
         if (req_end_of_input) begin
            mode_in  = MODE_IDLE;
            start_in = '0;
            pos_in   = '0;
            minus_in = 1'b0;
            halt_in  = 1'b0;
         end else begin
            mode_in  = mode_nx;
            start_in = start_nx;
            pos_in   = pos_inc;
            minus_in = minus_nx;
            halt_in  = halt_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         minus_ff <= 1'b0;
         halt_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         minus_ff <= minus_in;
         halt_ff  <= halt_in;
      end
   end

endmodule

>>> hdl/qtl_queue.sv
module qtl_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  qtl_pkg::qtl_bundle_type push_data,
   output logic                    full,
   input  logic                    pop,
   output qtl_pkg::qtl_bundle_type pop_data,
   output logic                    empty
);
   import qtl_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   qtl_bundle_type          entry_ff [QUEUE_DEPTH];
   logic [AW-1:0]           wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign full     = (cnt_ff == CW'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ff];

   // pointer and occupancy update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/qtl_back.sv
module qtl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  qtl_pkg::qtl_bundle_type q_data,
   output logic                    q_pop,
   output logic                    empty,
   input  logic                    pop,
   output logic [1:0]              rsp_result_type,
   output logic [3:0]              rsp_token_kind,
   output logic [2:0]              rsp_op_code,
   output logic [7:0]              rsp_content_byte,
   output logic [15:0]             rsp_position,
   output logic [15:0]             rsp_span_length,
   output logic [1:0]              rsp_error_code,
   output logic                    rsp_last_of_run
);
   import qtl_pkg::*;

   qtl_bundle_type cur_ff, cur_in;
   logic           valid_ff, valid_in;
   logic [1:0]     sel_ff, sel_in;
   logic           last, advance, load;
   qtl_result_type head;

   // the request being delivered and the slot shown
   assign last    = ({1'b0, sel_ff} + 3'd1) == cur_ff.count;
   assign advance = pop && valid_ff;
   assign load    = !q_empty && (!valid_ff || (advance && last));
   assign q_pop   = load;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         cur_in   = q_data;
         valid_in = 1'b1;
         sel_in   = '0;
      end else if (advance) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            sel_in = sel_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // result ports
   assign head             = cur_ff.slot[sel_ff];
   assign empty            = !valid_ff;
   assign rsp_result_type  = head.res_type;
   assign rsp_token_kind   = head.token_kind;
   assign rsp_op_code      = head.op_code;
   assign rsp_content_byte = head.content_byte;
   assign rsp_position     = head.position;
   assign rsp_span_length  = head.span_length;
   assign rsp_error_code   = head.error_code;
   assign rsp_last_of_run  = last;

endmodule

>>> hdl/query_token_lexer.sv
// query text tokenizer, one source byte per request
// request side: drive req_char_in and req_end_of_input with push; the byte is
//   taken at a clock edge where push is high and full is low. end_of_input marks
//   the last byte of a text; the next byte starts a new text at position 0.
// result side: while empty is low the oldest result is on the rsp_ ports; it is
//   taken at a clock edge where pop is high. rsp_last_of_run flags the final
//   result caused by one byte; whitespace and most opening bytes cause none.
// a result is registered in the queue and then in the serializer before it is shown.
// throughput: one byte per cycle while each byte causes at most one result and pop
//   stays high; the result side delivers one result per cycle while pop is high, so
//   bytes causing two to four results can hold the request side while they drain.
//   The result serializer sets the output rate.
// a two-entry queue of per-byte result groups sits between the lexer and the
//   serializer; when the receiver stalls it fills and full rises.
// reset (synchronous) returns the lexer to idle at position 0 and drops all
//   waiting results. After an error no results come until the end of the text.
module query_token_lexer #(
   parameter int POSITION_WIDTH = qtl_pkg::POSITION_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_input,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_type,
   output logic [3:0]  rsp_token_kind,
   output logic [2:0]  rsp_op_code,
   output logic [7:0]  rsp_content_byte,
   output logic [15:0] rsp_position,
   output logic [15:0] rsp_span_length,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run
);
   import qtl_pkg::*;

   qtl_bundle_type push_data, pop_data;
   logic           q_push, q_full, q_pop, q_empty;

   // lexer
   qtl_front #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_char_in      (req_char_in),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (push_data)
   );

   // result group queue
   qtl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // result serializer
   qtl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (pop_data),
      .q_pop            (q_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_type  (rsp_result_type),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_op_code      (rsp_op_code),
      .rsp_content_byte (rsp_content_byte),
      .rsp_position     (rsp_position),
      .rsp_span_length  (rsp_span_length),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   assign full = q_full;

endmodule

>>> hdl/qtl_checker.sv
module qtl_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [1:0]  rsp_result_type,
   input logic [3:0]  rsp_token_kind,
   input logic [15:0] rsp_position,
   input logic [15:0] rsp_span_length,
   input logic        rsp_last_of_run
);
   import qtl_pkg::*;

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("results present after reset");

   // a shown result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_result_type) && $stable(rsp_token_kind)
                            && $stable(rsp_position) && $stable(rsp_last_of_run)))
      else $error("result changed while stalled");

   // an error ends the run of its byte
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_result_type == RES_ERROR)) |-> rsp_last_of_run)
      else $error("error not last of run");

   // the end marker ends the run of its byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_result_type == RES_TOKEN) && (rsp_token_kind == KIND_END))
      |-> (rsp_last_of_run && (rsp_span_length == 16'd0)))
      else $error("end marker not last of run");

   // content bytes carry no position
   a_content_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_result_type == RES_CONTENT))
      |-> ((rsp_position == 16'd0) && (rsp_span_length == 16'd0)))
      else $error("content result with position or span");

endmodule

bind query_token_lexer qtl_checker u_qtl_checker (
   .clock           (clock),
   .reset           (reset),
   .empty           (empty),
   .pop             (pop),
   .rsp_result_type (rsp_result_type),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_position    (rsp_position),
   .rsp_span_length (rsp_span_length),
   .rsp_last_of_run (rsp_last_of_run)
);

>>> tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import qtl_pkg::*;

   localparam int POS_MAX     = 65535;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_BYTES = 280;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_PRINTED = 30;

   // fields that are zero where they do not apply
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [3:0] KIND_NONE = 4'd0;
   localparam logic [1:0] ERR_NONE  = 2'd0;

   typedef enum logic [3:0] {
      LX_IDLE, LX_STR, LX_STR_ESC, LX_RGX, LX_RGX_ESC, LX_INT, LX_FRAC,
      LX_WORD, LX_LT, LX_GT, LX_BANG, LX_SIGN
   } lex_mode_type;

   typedef struct packed {
      logic [1:0]  rtype;
      logic [3:0]  kind;
      logic [2:0]  op;
      logic [7:0]  cbyte;
      logic [15:0] pos;
      logic [15:0] span;
      logic [1:0]  err;
      logic        last;
   } lex_result_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
      logic       quick;
   } src_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [7:0]  req_char_in = '0;
   logic        req_end_of_input = 1'b0;
   logic        full;
   logic        empty;
   logic [1:0]  rsp_result_type;
   logic [3:0]  rsp_token_kind;
   logic [2:0]  rsp_op_code;
   logic [7:0]  rsp_content_byte;
   logic [15:0] rsp_position;
   logic [15:0] rsp_span_length;
   logic [1:0]  rsp_error_code;
   logic        rsp_last_of_run;

   query_token_lexer DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_char_in      (req_char_in),
      .req_end_of_input (req_end_of_input),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_type  (rsp_result_type),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_op_code      (rsp_op_code),
      .rsp_content_byte (rsp_content_byte),
      .rsp_position     (rsp_position),
      .rsp_span_length  (rsp_span_length),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // lexer shadow state
   lex_mode_type   lx_mode = LX_IDLE;
   int             tok_start = 0;
   int             next_pos = 0;
   bit             sign_minus = 1'b0;
   bit             halted = 1'b0;
   lex_result_type step_out [4];
   int             step_n;

   lex_result_type results_due [$];
   src_byte_type   pending_bytes [$];
   logic [7:0]     text_buf [$];

   // bookkeeping
   int mismatches = 0;
   int results_checked = 0;
   int contents_seen = 0;
   int tokens_seen = 0;
   int errors_seen = 0;
   int texts_queued = 0;
   int bytes_queued = 0;
   int clean_bytes = 0;
   int cycle_count = 0;

   // handshake state shared between the clock edges
   src_byte_type req_now = '0;
   bit        req_busy = 1'b0;
   bit        req_taken = 1'b0;
   bit        req_gap_set = 1'b0;
   int        req_gap = 0;
   int        req_calm = 0;
   bit        rush = 1'b0;
   bit        rsp_taken = 1'b0;
   bit        rsp_gap_set = 1'b0;
   int        rsp_gap = 0;
   int        rsp_calm = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // character classes, ASCII only
   function automatic bit digit_ch(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit letter_ch(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit blank_ch(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit word_tail(input logic [7:0] c);
      return letter_ch(c) || digit_ch(c) || c == CH_UNDER || c == CH_DOT || c == CH_COLON;
   endfunction

   function automatic int sat_inc(input int p);
      return (p >= POS_MAX) ? POS_MAX : p + 1;
   endfunction

   function automatic int span_to(input int end_excl);
      int s;
      s = (end_excl >= tok_start) ? end_excl - tok_start : 0;
      return (s > POS_MAX) ? POS_MAX : s;
   endfunction

   task automatic add_result(input logic [1:0] rt, input logic [3:0] kind,
                             input logic [2:0] op, input logic [7:0] b, input int pos,
                             input int span, input logic [1:0] err);
      lex_result_type r;
      if (step_n < MAX_RESULTS) begin
         r.rtype = rt;
         r.kind  = kind;
         r.op    = op;
         r.cbyte = b;
         r.pos   = pos[15:0];
         r.span  = span[15:0];
         r.err   = err;
         r.last  = 1'b0;
         step_out[step_n] = r;
         step_n++;
      end
   endtask

   task automatic add_content(input logic [7:0] b);
      add_result(RES_CONTENT, KIND_NONE, OP_NONE, b, 0, 0, ERR_NONE);
   endtask

   task automatic add_token(input logic [3:0] kind, input logic [2:0] op, input int pos,
                            input int span);
      add_result(RES_TOKEN, kind, op, 8'h00, pos, span, ERR_NONE);
   endtask

   task automatic halt_with(input logic [1:0] code, input int pos);
      add_result(RES_ERROR, KIND_NONE, OP_NONE, 8'h00, pos, 0, code);
      halted = 1'b1;
      lx_mode = LX_IDLE;
   endtask

   // a byte seen with no token open
   task automatic lex_fresh(input logic [7:0] c, input int pos);
      tok_start = pos;
      if (blank_ch(c)) begin
      end else if (c == CH_QUOTE) begin
         lx_mode = LX_STR;
      end else if (c == CH_SLASH) begin
         lx_mode = LX_RGX;
      end else if (digit_ch(c)) begin
         add_content(c);
         lx_mode = LX_INT;
      end else if (c == CH_MINUS || c == CH_PLUS) begin
         sign_minus = (c == CH_MINUS);
         lx_mode = LX_SIGN;
      end else if (c == CH_EQUAL) begin
         add_token(KIND_OP, OP_EQ, pos, 1);
      end else if (c == CH_BANG) begin
         lx_mode = LX_BANG;
      end else if (c == CH_LESS) begin
         lx_mode = LX_LT;
      end else if (c == CH_MORE) begin
         lx_mode = LX_GT;
      end else if (c == CH_STAR) begin
         add_token(KIND_OP, OP_STAR, pos, 1);
      end else if (c == CH_LPAREN) begin
         add_token(KIND_LPAREN, OP_NONE, pos, 1);
      end else if (c == CH_RPAREN) begin
         add_token(KIND_RPAREN, OP_NONE, pos, 1);
      end else if (c == CH_COMMA) begin
         add_token(KIND_COMMA, OP_NONE, pos, 1);
      end else if (letter_ch(c) || c == CH_UNDER) begin
         add_content(c);
         lx_mode = LX_WORD;
      end else begin
         halt_with(ERR_UNEXPECTED, pos);
      end
   endtask

   // one byte against the open token
   task automatic lex_step(input logic [7:0] c, input int pos);
      logic [2:0] op_alone;
      logic [2:0] op_eq;
      case (lx_mode)
         LX_STR: begin
            if (c == CH_BSLASH) begin
               lx_mode = LX_STR_ESC;
            end else if (c == CH_QUOTE) begin
               add_token(KIND_STRING, OP_NONE, tok_start, span_to(sat_inc(pos)));
               lx_mode = LX_IDLE;
            end else begin
               add_content(c);
            end
         end
         LX_STR_ESC: begin
            add_content(c);
            lx_mode = LX_STR;
         end
         LX_RGX: begin
            if (c == CH_BSLASH) begin
               add_content(c);
               lx_mode = LX_RGX_ESC;
            end else if (c == CH_SLASH) begin
               add_token(KIND_REGEX, OP_NONE, tok_start, span_to(sat_inc(pos)));
               lx_mode = LX_IDLE;
            end else begin
               add_content(c);
            end
         end
         LX_RGX_ESC: begin
            add_content(c);
            lx_mode = LX_RGX;
         end
         LX_SIGN: begin
            if (digit_ch(c)) begin
               add_content(sign_minus ? CH_MINUS : CH_PLUS);
               add_content(c);
               lx_mode = LX_INT;
            end else begin
               halt_with(ERR_UNEXPECTED, tok_start);
            end
            sign_minus = 1'b0;
         end
         LX_BANG: begin
            if (c == CH_EQUAL) begin
               add_token(KIND_OP, OP_NE, tok_start, span_to(sat_inc(pos)));
               lx_mode = LX_IDLE;
            end else begin
               halt_with(ERR_BANG, tok_start);
            end
         end
         LX_LT, LX_GT: begin
            op_alone = (lx_mode == LX_LT) ? OP_LT : OP_GT;
            op_eq    = (lx_mode == LX_LT) ? OP_LE : OP_GE;
            lx_mode = LX_IDLE;
            if (c == CH_EQUAL) begin
               add_token(KIND_OP, op_eq, tok_start, span_to(sat_inc(pos)));
            end else begin
               add_token(KIND_OP, op_alone, tok_start, 1);
               lex_fresh(c, pos);
            end
         end
         LX_INT, LX_FRAC: begin
            if (digit_ch(c)) begin
               add_content(c);
            end else if (lx_mode == LX_INT && c == CH_DOT) begin
               add_content(c);
               lx_mode = LX_FRAC;
            end else begin
               add_token(KIND_NUMBER, OP_NONE, tok_start, span_to(pos));
               lx_mode = LX_IDLE;
               lex_fresh(c, pos);
            end
         end
         LX_WORD: begin
            if (word_tail(c)) begin
               add_content(c);
            end else begin
               add_token(KIND_WORD, OP_NONE, tok_start, span_to(pos));
               lx_mode = LX_IDLE;
               lex_fresh(c, pos);
            end
         end
         default: begin
            lx_mode = LX_IDLE;
            lex_fresh(c, pos);
         end
      endcase
   endtask

   // close whatever is open at the last byte, then the end marker unless closing halts
   task automatic lex_close(input int end_pos);
      case (lx_mode)
         LX_STR, LX_STR_ESC: begin
            halt_with(ERR_OPEN_STRING, tok_start);
            return;
         end
         LX_RGX, LX_RGX_ESC: begin
            halt_with(ERR_OPEN_REGEX, tok_start);
            return;
         end
         LX_BANG: begin
            halt_with(ERR_BANG, tok_start);
            return;
         end
         LX_SIGN: begin
            halt_with(ERR_UNEXPECTED, tok_start);
            return;
         end
         LX_INT, LX_FRAC: add_token(KIND_NUMBER, OP_NONE, tok_start, span_to(end_pos));
         LX_WORD: add_token(KIND_WORD, OP_NONE, tok_start, span_to(end_pos));
         LX_LT: add_token(KIND_OP, OP_LT, tok_start, 1);
         LX_GT: add_token(KIND_OP, OP_GT, tok_start, 1);
         default: begin
         end
      endcase
      add_token(KIND_END, OP_NONE, end_pos, 0);
   endtask

   // results one accepted request should cause
   task automatic lex_byte(input logic [7:0] c, input logic eoi);
      int pos;
      int i;
      pos = next_pos;
      step_n = 0;
      if (!halted) begin
         lex_step(c, pos);
         if (eoi && !halted)
            lex_close(sat_inc(pos));
      end
      next_pos = sat_inc(pos);
      if (eoi) begin
         lx_mode = LX_IDLE;
         tok_start = 0;
         next_pos = 0;
         sign_minus = 1'b0;
         halted = 1'b0;
      end
      if (step_n > 0)
         step_out[step_n-1].last = 1'b1;
      for (i = 0; i < step_n; i++)
         results_due.insert(results_due.size(), step_out[i]);
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                   results_checked, name, got, want));
   endtask

   // wait before the next item: random, none while rushed or in a calm stretch
   task automatic draw_gap(input bit rushed, inout int calm, output int gap);
      if (rushed) begin
         gap = 0;
      end else if (calm > 0) begin
         calm--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 12);
      end
   endtask

   // text building
   task automatic put(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endtask

   task automatic put_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         put(s[i]);
   endtask

   task automatic put_blank();
      int k;
      k = $urandom_range(0, 5);
      put((k == 0) ? 8'h20 : 8'(8 + k));
   endtask

   task automatic flush_text(input bit quick);
      src_byte_type s;
      int i;
      for (i = 0; i < text_buf.size(); i++) begin
         s.ch = text_buf[i];
         s.eoi = (i == text_buf.size() - 1);
         s.quick = quick;
         pending_bytes.insert(pending_bytes.size(), s);
      end
      bytes_queued += text_buf.size();
      texts_queued++;
      text_buf.delete();
   endtask

   // quoted or slashed body, any byte, with escapes
   task automatic put_body(input logic [7:0] closer);
      int n;
      int i;
      logic [7:0] b;
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            put(CH_BSLASH);
            put(8'($urandom_range(0, 255)));
         end else begin
            b = 8'($urandom_range(0, 255));
            while (b == closer || b == CH_BSLASH)
               b = 8'($urandom_range(0, 255));
            put(b);
         end
      end
   endtask

   task automatic put_word();
      string heads;
      string tails;
      int n;
      int i;
      heads = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
      tails = "azAZ_09.:mQ7";
      put(heads[$urandom_range(0, heads.len() - 1)]);
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++)
         put(tails[$urandom_range(0, tails.len() - 1)]);
   endtask

   task automatic put_number();
      int n;
      int i;
      if ($urandom_range(0, 2) == 0)
         put($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++)
         put(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 1)) begin
         put(CH_DOT);
         n = $urandom_range(0, 3);
         for (i = 0; i < n; i++)
            put(8'("0" + $urandom_range(0, 9)));
      end
   endtask

   task automatic put_operator();
      case ($urandom_range(0, 6))
         0: put(CH_EQUAL);
         1: put_string("!=");
         2: put(CH_LESS);
         3: put_string("<=");
         4: put(CH_MORE);
         5: put_string(">=");
         default: put(CH_STAR);
      endcase
   endtask

   // a malformed piece; returns 1 when the text must end right after it
   task automatic put_broken(output bit stop);
      logic [7:0] closer;
      stop = 1'b0;
      closer = $urandom_range(0, 1) ? CH_QUOTE : CH_SLASH;
      case ($urandom_range(0, 4))
         0, 1: begin
            put(closer);
            put_body(closer);
         end
         2: begin
            put($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if ($urandom_range(0, 1))
               put("q");
         end
         3: begin
            put(CH_BANG);
            if ($urandom_range(0, 1))
               put("a");
         end
         default: begin
            put(closer);
            put_body(closer);
            put(CH_BSLASH);
            stop = 1'b1;
         end
      endcase
   endtask

   task automatic random_text();
      int ntok;
      int k;
      int pick;
      bit clean;
      bit stop;
      clean = 1'b1;
      stop = 1'b0;
      if ($urandom_range(0, 19) == 0) begin
         // blanks only: just the end marker
         ntok = $urandom_range(1, 3);
         for (k = 0; k < ntok; k++)
            put_blank();
      end else begin
         ntok = $urandom_range(1, 8);
         for (k = 0; k < ntok && !stop; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 16) begin
               put_word();
            end else if (pick < 30) begin
               put_number();
            end else if (pick < 42) begin
               put(CH_QUOTE);
               put_body(CH_QUOTE);
               put(CH_QUOTE);
            end else if (pick < 52) begin
               put(CH_SLASH);
               put_body(CH_SLASH);
               put(CH_SLASH);
            end else if (pick < 72) begin
               put_operator();
            end else if (pick < 84) begin
               case ($urandom_range(0, 2))
                  0: put(CH_LPAREN);
                  1: put(CH_RPAREN);
                  default: put(CH_COMMA);
               endcase
            end else if (pick < 92) begin
               put_broken(stop);
               clean = 1'b0;
            end else begin
               put(8'($urandom_range(0, 255)));
               clean = 1'b0;
            end
            if (!stop && $urandom_range(0, 2) != 0)
               put_blank();
         end
      end
      if (clean)
         clean_bytes += text_buf.size();
      flush_text(1'b0);
   endtask

   // stimulus
   initial begin
      // operators, signed fraction, bare fraction, marks
      put_string("(x>=-1.5,y!=2.)");
      flush_text(1'b0);
      // lone less-than before a string with an escape
      put_string("<\"\\q\"");
      flush_text(1'b0);
      // sign with no digit, then halted up to the end
      put_string("+!");
      flush_text(1'b0);
      // regex cut off after a backslash
      put_string("/\\");
      flush_text(1'b0);
      put(8'hFF);
      flush_text(1'b0);
      // a mixed text sent with no gaps on either side
      put_string("\"ab\\\"c\" <= 12 ab.c:d*(/x\\/y/)");
      flush_text(1'b1);
      while (bytes_queued < RANDOM_BYTES)
         random_text();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_bytes.size() > 0 || req_busy)
         @(posedge clock);
      while (results_due.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (results_due.size() > 0)
         report_mismatch($sformatf("%0d expected results never came", results_due.size()));
      $display("sent %0d texts, %0d source bytes, %0d of them in well-formed random texts",
               texts_queued, bytes_queued, clean_bytes);
      $display("checked %0d results: %0d content, %0d token, %0d error, %0d mismatches",
               results_checked, contents_seen, tokens_seen, errors_seen, mismatches);
      if (mismatches == 0)
         $display("query_token_lexer regression: pass");
      else
         $display("query_token_lexer regression: fail");
      $finish;
   end

   // request accepted: predict its results
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         lex_byte(req_char_in, req_end_of_input);
         rush = req_now.quick;
         req_taken = 1'b1;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_busy = 1'b0;
         end
         if (!req_busy && pending_bytes.size() > 0) begin
            if (!req_gap_set) begin
               draw_gap(pending_bytes[0].quick, req_calm, req_gap);
               req_gap_set = 1'b1;
            end
            if (req_gap > 0) begin
               req_gap--;
            end else begin
               req_now = pending_bytes.pop_front();
               req_busy = 1'b1;
               req_gap_set = 1'b0;
            end
         end
         push <= req_busy;
         req_char_in <= req_now.ch;
         req_end_of_input <= req_now.eoi;
      end
   end

   // result monitor and run limit
   always @(posedge clock) begin
      lex_result_type want;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles, %0d requests and %0d results waiting",
                     $realtime, cycle_count, pending_bytes.size(), results_due.size());
            $display("query_token_lexer regression: fail");
            $finish;
         end else if (pop && !empty) begin
            rsp_taken = 1'b1;
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         results_checked));
            end else begin
               want = results_due.pop_front();
               check_field("result_type", rsp_result_type, want.rtype);
               check_field("token_kind", rsp_token_kind, want.kind);
               check_field("op_code", rsp_op_code, want.op);
               check_field("content_byte", rsp_content_byte, want.cbyte);
               check_field("position", rsp_position, want.pos);
               check_field("span_length", rsp_span_length, want.span);
               check_field("error_code", rsp_error_code, want.err);
               check_field("last_of_run", rsp_last_of_run, want.last);
               case (want.rtype)
                  RES_CONTENT: contents_seen++;
                  RES_TOKEN: tokens_seen++;
                  default: errors_seen++;
               endcase
            end
            results_checked++;
         end
      end
   end

   // result side stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_gap_set = 1'b0;
         end
         if (!rsp_gap_set) begin
            draw_gap(rush, rsp_calm, rsp_gap);
            rsp_gap_set = 1'b1;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

endmodule
